// ===== hdl/neighbor_table_with_aging_defines.svh =====
// Assertion macros shared by the neighbor table RTL.
// Used by neighbor_table_with_aging.sv; needs no other file.
`ifndef NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH
`define NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define NBT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/nbt_pkg.sv =====
// Types, widths and codes of the neighbor table with aging.
// Depends on nothing; nbt_ifs and neighbor_table_with_aging import it.
`default_nettype none

package nbt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam int ADDR_W   = 16;
   localparam int RANK_W   = 16;
   localparam int AGE_W    = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int EXP_W    = 5;
   localparam int ENTRY_W  = RANK_W + ADDR_W + AGE_W;

   localparam logic [AGE_W-1:0] AGE_TIMEOUT_RESET = 16'd7680;

   typedef enum logic {
      FUNC_ANNOUNCE = 1'b0,
      FUNC_TICK     = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_REFRESHED = 2'd0,
      ST_INSERTED  = 2'd1,
      ST_FULL      = 2'd2,
      ST_TICK      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [ADDR_W-1:0] addr;
      logic [AGE_W-1:0]  age;
   } entry_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [EXP_W-1:0]  expired_count;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/nbt_ifs.sv =====
// Valid/ready channel interfaces of the neighbor table: request, response, register write.
// Depends on nbt_pkg for the field widths.
`default_nettype none

interface nbt_req_if;
   import nbt_pkg::*;
   logic              valid;
   logic              ready;
   logic              func;
   logic [ADDR_W-1:0] sender_addr;
   logic [RANK_W-1:0] sender_rank;
   modport source (output valid, output func, output sender_addr, output sender_rank,
                   input ready);
   modport sink   (input valid, input func, input sender_addr, input sender_rank,
                   output ready);
endinterface

interface nbt_rsp_if;
   import nbt_pkg::*;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SLOT_W-1:0]   slot;
   logic [EXP_W-1:0]    expired_count;
   modport source (output valid, output status, output slot, output expired_count,
                   input ready);
   modport sink   (input valid, input status, input slot, input expired_count,
                   output ready);
endinterface

interface nbt_csr_if;
   import nbt_pkg::*;
   logic             valid;
   logic             ready;
   logic [AGE_W-1:0] age_timeout;
   modport source (output valid, output age_timeout, input ready);
   modport sink   (input valid, input age_timeout, output ready);
endinterface

`default_nettype wire

// ===== hdl/nbt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module nbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/neighbor_table_with_aging.sv =====
// Neighbor table keyed by node address, with an age timer per entry. Addresses, ranks
// and timers live in one RAM; valid bits are flip-flops that reset clears, so the table
// is usable right after reset. Each item walks all TABLE_ENTRIES entries through the
// RAM's single read port, one entry per cycle. Its result is registered and moves to
// the output register in SEQ_DONE once that register is free; a new item is accepted
// only in SEQ_IDLE, so it is not taken before the last item is through its scan;
// an announcement that hits an existing address finishes as soon as that entry is read.
// The response sits in an output register, so the next item is taken while a result
// still waits. The user writes age_timeout through the register port only while the
// block is idle; the block itself does not enforce this.
// Depends on nbt_pkg, nbt_ifs, nbt_ram and neighbor_table_with_aging_defines.svh.
`default_nettype none
`include "neighbor_table_with_aging_defines.svh"

module neighbor_table_with_aging (
   input logic      clock,
   input logic      reset,
   nbt_req_if.sink   req_chan,
   nbt_rsp_if.source rsp_chan,
   nbt_csr_if.sink   csr_chan
);
   import nbt_pkg::*;

   seq_state_type           state_ff, state_in;
   func_type                func_ff;
   logic [ADDR_W-1:0]       addr_ff;
   logic [RANK_W-1:0]       rank_ff;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    chk_ff;
   logic [IDX_W-1:0]        chk_idx_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                    free_found_ff, free_found_in;
   logic [IDX_W-1:0]        free_idx_ff, free_idx_in;
   logic [CNT_W-1:0]        expired_ff, expired_in;
   result_type              res_ff, res_in;
   result_type              rsp_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AGE_W-1:0]        timeout_ff;

   logic                    accept;
   logic                    rsp_load;
   logic                    scan_end;
   logic                    live;
   logic                    hit;
   logic                    rd_en;
   logic [IDX_W-1:0]        rd_addr;
   entry_type               rd_data;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   entry_type               wr_data;

   nbt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_chan.ready = (state_ff == SEQ_IDLE);
   assign csr_chan.ready = 1'b1;
   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_load = (state_ff == SEQ_DONE) && (!rsp_valid_ff || rsp_chan.ready);

   assign rd_en    = (state_ff == SEQ_SCAN) && (cnt_ff < CNT_W'(TABLE_ENTRIES));
   assign rd_addr  = cnt_ff[IDX_W-1:0];
   assign scan_end = (state_ff == SEQ_SCAN) && (cnt_ff == CNT_W'(TABLE_ENTRIES)) && !chk_ff;
   assign live     = valid_ff[chk_idx_ff];
   assign hit      = (state_ff == SEQ_SCAN) && chk_ff && live && (func_ff == FUNC_ANNOUNCE)
                     && (rd_data.addr == addr_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            if (hit || scan_end) begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_DONE: begin
            if (rsp_load) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      cnt_in        = cnt_ff;
      valid_in      = valid_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      expired_in    = expired_ff;
      res_in        = res_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_idx_ff;
      wr_data       = rd_data;

      if (accept) begin
         cnt_in        = '0;
         free_found_in = 1'b0;
         free_idx_in   = '0;
         expired_in    = '0;
      end
      if (rd_en) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if ((state_ff == SEQ_SCAN) && chk_ff) begin
         if (func_ff == FUNC_TICK) begin
            if (live) begin
               wr_en = 1'b1;
               if (rd_data.age <= AGE_W'(1)) begin
                  wr_data.age          = '0;
                  valid_in[chk_idx_ff] = 1'b0;
                  expired_in           = expired_ff + CNT_W'(1);
               end else begin
                  wr_data.age = rd_data.age - AGE_W'(1);
               end
            end
         end else if (hit) begin
            wr_en       = 1'b1;
            wr_data.age = timeout_ff;
            res_in      = '{status: ST_REFRESHED, slot: SLOT_W'(chk_idx_ff),
                            expired_count: '0};
         end else if (!live && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_idx_ff;
         end
      end

      if (scan_end) begin
         if (func_ff == FUNC_TICK) begin
            res_in = '{status: ST_TICK, slot: '0, expired_count: EXP_W'(expired_ff)};
         end else if (free_found_ff) begin
            wr_en                 = 1'b1;
            wr_addr               = free_idx_ff;
            wr_data               = '{rank: rank_ff, addr: addr_ff, age: timeout_ff};
            valid_in[free_idx_ff] = 1'b1;
            res_in = '{status: ST_INSERTED, slot: SLOT_W'(free_idx_ff), expired_count: '0};
         end else begin
            res_in = '{status: ST_FULL, slot: '0, expired_count: '0};
         end
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         cnt_ff        <= '0;
         chk_ff        <= 1'b0;
         valid_ff      <= '0;
         free_found_ff <= 1'b0;
         expired_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         timeout_ff    <= AGE_TIMEOUT_RESET;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         chk_ff        <= rd_en;
         valid_ff      <= valid_in;
         free_found_ff <= free_found_in;
         expired_ff    <= expired_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            timeout_ff <= csr_chan.age_timeout;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_chan.func);
         addr_ff <= req_chan.sender_addr;
         rank_ff <= req_chan.sender_rank;
      end
      if (rd_en) begin
         chk_idx_ff <= rd_addr;
      end
      free_idx_ff <= free_idx_in;
      res_ff      <= res_in;
      if (rsp_load) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_ff.status;
   assign rsp_chan.slot          = rsp_ff.slot;
   assign rsp_chan.expired_count = rsp_ff.expired_count;

   `NBT_ASSERT_SAME(a_wr_only_scan, clock, reset, wr_en, state_ff == SEQ_SCAN,
      "Table write outside of a scan.")
   `NBT_ASSERT_NEXT(a_fill_by_one, clock, reset, 1'b1,
      $countones(valid_ff) <= $countones($past(valid_ff)) + 1,
      "More than one entry filled by one item.")
   `NBT_ASSERT_SAME(a_expired_tick, clock, reset,
      rsp_chan.valid && (rsp_chan.status != ST_TICK), rsp_chan.expired_count == '0,
      "Expired count reported for an announcement.")
   `NBT_ASSERT_NEXT(a_scan_start, clock, reset, accept,
      (state_ff == SEQ_SCAN) && (cnt_ff == '0) && !chk_ff,
      "Scan did not start at entry zero after an item.")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the neighbor table with aging: a stimulus table, then random phases.
// Each phase sets a new timeout. Results are checked against a predictor of the table,
// or against fixed values for the table rows. Depends on nbt_pkg, nbt_ifs and neighbor_table_with_aging.
`timescale 1ns / 1ps

module tb;
   import nbt_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int MAX_WAIT    = 7;
   localparam int ADDR_POOL   = 24;
   localparam int PHASES      = 12;
   localparam int PHASE_ITEMS = 60;
   localparam int TAIL_CYCLES = 40;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      func_type          func;
      logic [ADDR_W-1:0] addr;
      logic [RANK_W-1:0] rank;
   } req_item_type;

   typedef struct {
      bit               set_timeout;
      logic [AGE_W-1:0] timeout;
      req_item_type     item;
      bit               fixed;
      result_type       want;
   } plan_row_type;

   logic clock;
   logic reset;

   nbt_req_if req_bus ();
   nbt_rsp_if rsp_bus ();
   nbt_csr_if csr_bus ();

   neighbor_table_with_aging dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   bit               nb_live    [TABLE_ENTRIES];
   logic [ADDR_W-1:0] nb_addr   [TABLE_ENTRIES];
   logic [RANK_W-1:0] nb_rank   [TABLE_ENTRIES];
   logic [AGE_W-1:0]  nb_age    [TABLE_ENTRIES];
   logic [AGE_W-1:0]  nb_timeout;

   result_type        expected_q [$];
   plan_row_type      plan [$];
   logic [ADDR_W-1:0] addr_pool [ADDR_POOL];
   int unsigned       span_plan [PHASES] = '{3, 1, 2, 5, 1, 8, 4, 2, 12, 6, 0, 65535};

   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned rsp_hold = 0;
   bit          calm = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned draw_wait();
      return calm ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Applies one item to the table copy and returns the result it gives.
   function automatic result_type apply_item(input req_item_type it);
      result_type  r;
      int          hit;
      int unsigned freed;
      r.status        = ST_TICK;
      r.slot          = '0;
      r.expired_count = '0;
      hit   = -1;
      freed = 0;
      if (it.func == FUNC_TICK) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (nb_live[i]) begin
               if (nb_age[i] <= 1) begin
                  nb_age[i]  = '0;
                  nb_live[i] = 1'b0;
                  freed++;
               end else begin
                  nb_age[i] = nb_age[i] - 1'b1;
               end
            end
         end
         r.expired_count = freed[EXP_W-1:0];
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit < 0 && nb_live[i] && nb_addr[i] == it.addr) hit = i;
         end
         if (hit >= 0) begin
            nb_age[hit] = nb_timeout;
            r.status    = ST_REFRESHED;
            r.slot      = hit[SLOT_W-1:0];
         end else begin
            r.status = ST_FULL;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (hit < 0 && !nb_live[i]) begin
                  hit        = i;
                  nb_live[i] = 1'b1;
                  nb_addr[i] = it.addr;
                  nb_rank[i] = it.rank;
                  nb_age[i]  = nb_timeout;
                  r.status   = ST_INSERTED;
                  r.slot     = hit[SLOT_W-1:0];
               end
            end
         end
      end
      return r;
   endfunction

   function automatic void add_row(input bit set_t, input logic [AGE_W-1:0] t,
                                   input func_type f, input logic [ADDR_W-1:0] a,
                                   input logic [RANK_W-1:0] rk, input bit fixed,
                                   input result_type want);
      plan_row_type row;
      row.set_timeout = set_t;
      row.timeout     = t;
      row.item.func   = f;
      row.item.addr   = a;
      row.item.rank   = rk;
      row.fixed       = fixed;
      row.want        = want;
      plan.push_back(row);
   endfunction

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [AGE_W-1:0] value);
      wait_drained();
      csr_bus.valid       <= 1'b1;
      csr_bus.age_timeout <= value;
      do @(posedge clock); while (!csr_bus.ready);
      nb_timeout = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_item(input req_item_type it, input bit fixed, input result_type want);
      int unsigned gap;
      result_type  predicted;
      gap = draw_wait();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= it.func;
      req_bus.sender_addr <= it.addr;
      req_bus.sender_rank <= it.rank;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_item(it);
      expected_q.push_back(fixed ? want : predicted);
   endtask

   always @(posedge clock) begin : rsp_check
      result_type  want;
      int unsigned stall;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold      <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("Unexpected result: status %0d slot %0d expired %0d",
                           rsp_bus.status, rsp_bus.slot, rsp_bus.expired_count);
            end else begin
               want = expected_q.pop_front();
               if (rsp_bus.status !== want.status || rsp_bus.slot !== want.slot ||
                   rsp_bus.expired_count !== want.expired_count) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("Mismatch: expected status %0d slot %0d expired %0d, %s %0d %0d %0d",
                              want.status, want.slot, want.expired_count, "got",
                              rsp_bus.status, rsp_bus.slot, rsp_bus.expired_count);
               end
            end
            stall = draw_wait();
            if (stall != 0) begin
               rsp_bus.ready <= 1'b0;
               rsp_hold      <= stall - 1;
            end
         end else if (!rsp_bus.ready) begin
            if (rsp_hold == 0) rsp_bus.ready <= 1'b1;
            else rsp_hold <= rsp_hold - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles.", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      req_item_type it;
      int unsigned  span;
      int unsigned  tick_pct;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= FUNC_ANNOUNCE;
      req_bus.sender_addr <= '0;
      req_bus.sender_rank <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.age_timeout <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         nb_live[i] = 1'b0;
         nb_addr[i] = '0;
         nb_rank[i] = '0;
         nb_age[i]  = '0;
      end
      nb_timeout = AGE_TIMEOUT_RESET;
      for (int i = 0; i < ADDR_POOL; i++) addr_pool[i] = ADDR_W'($urandom_range(0, 65535));

      add_row(0, 0, FUNC_TICK, 16'h0000, 16'h0000, 1, '{ST_TICK, 4'd0, 5'd0});
      add_row(0, 0, FUNC_ANNOUNCE, 16'h0000, 16'h0000, 1, '{ST_INSERTED, 4'd0, 5'd0});
      add_row(1, 16'd1, FUNC_ANNOUNCE, 16'hFFFF, 16'hFFFF, 1, '{ST_INSERTED, 4'd1, 5'd0});
      add_row(0, 0, FUNC_ANNOUNCE, 16'h0000, 16'h1234, 1, '{ST_REFRESHED, 4'd0, 5'd0});
      add_row(0, 0, FUNC_TICK, 16'hFFFF, 16'hFFFF, 1, '{ST_TICK, 4'd0, 5'd2});
      for (int k = 0; k < TABLE_ENTRIES; k++)
         add_row(0, 0, FUNC_ANNOUNCE, ADDR_W'(16'h0100 + k), RANK_W'(16'hF0F0 ^ k), 0, '0);
      add_row(0, 0, FUNC_ANNOUNCE, 16'hA5A5, 16'h5A5A, 1, '{ST_FULL, 4'd0, 5'd0});
      add_row(0, 0, FUNC_TICK, 16'h0000, 16'h0000, 1, '{ST_TICK, 4'd0, 5'd16});
      add_row(1, 16'hFFFF, FUNC_ANNOUNCE, 16'h1234, 16'h8001, 1, '{ST_INSERTED, 4'd0, 5'd0});
      add_row(1, 16'd1, FUNC_ANNOUNCE, 16'h1234, 16'h0000, 1, '{ST_REFRESHED, 4'd0, 5'd0});
      add_row(0, 0, FUNC_TICK, 16'h7FFF, 16'h8000, 1, '{ST_TICK, 4'd0, 5'd1});

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[n]) begin
         if (plan[n].set_timeout) begin
            req_bus.valid <= 1'b0;
            write_timeout(plan[n].timeout);
         end
         send_item(plan[n].item, plan[n].fixed, plan[n].want);
      end
      req_bus.valid <= 1'b0;

      // Entries from one phase outlive it, so the long timeouts come last.
      for (int phase = 0; phase < PHASES; phase++) begin
         span = (span_plan[phase] == 0) ? $urandom_range(1, 65535) : span_plan[phase];
         write_timeout(span[AGE_W-1:0]);
         calm     = ($urandom_range(0, 3) == 0);
         tick_pct = $urandom_range(3, 40);
         repeat (PHASE_ITEMS) begin
            it.func = ($urandom_range(0, 99) < tick_pct) ? FUNC_TICK : FUNC_ANNOUNCE;
            it.addr = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, ADDR_POOL - 1)]
                                                   : ADDR_W'($urandom_range(0, 65535));
            it.rank = RANK_W'($urandom_range(0, 65535));
            send_item(it, 0, '0);
         end
         req_bus.valid <= 1'b0;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/nbt_pkg.sv
hdl/nbt_ifs.sv
hdl/nbt_ram.sv
hdl/neighbor_table_with_aging.sv
sim/tb.sv
